>>> hdl/compact_integer_stream_decoder_defines.svh
// Assertion macros for the compact integer stream decoder.
`ifndef COMPACT_INTEGER_STREAM_DECODER_DEFINES_SVH
`define COMPACT_INTEGER_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// cond holds -> prop holds in the same cycle
`define CISD_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("cisd: implication check failed");
// cond holds -> prop holds in the next cycle
`define CISD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("cisd: next-cycle check failed");
`else
`define CISD_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define CISD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

>>> hdl/cisd_pkg.sv
// Types and constants shared by the compact integer decoder modules.
`timescale 1ns / 1ps

package cisd_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned LenW   = 7;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_TWO    = 2'd1,
    MODE_FOUR   = 2'd2,
    MODE_BIG    = 2'd3
  } mode_t;

  typedef enum logic {
    ST_HEADER = 1'b0,
    ST_BODY   = 1'b1
  } dec_state_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EARLY_END = 1'b1;

  // big-mode payload bytes beyond the header
  localparam logic [LenW-1:0] BIG_EXTRA = 7'd4;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   total_length;
    logic              is_big;
    logic              big_overflow;
    logic              non_canonical;
    logic              status;
  } res_t;

endpackage

>>> hdl/cisd_core.sv
// Decode state and per-byte step logic of the compact integer decoder.
`timescale 1ns / 1ps

module cisd_core import cisd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       res_valid,
  output res_t       res
);

  dec_state_t       state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [LenW-1:0]  left_r, left_nxt;
  logic [LenW-1:0]  seen_r, seen_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic             hinz_r, hinz_nxt;

  mode_t            mode_in;
  logic [LenW-1:0]  k;
  logic [LenW-1:0]  left_dec;
  logic             noncanon;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
      mode_r  <= MODE_SINGLE;
      left_r  <= '0;
      seen_r  <= '0;
      hinz_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      left_r  <= left_nxt;
      seen_r  <= seen_nxt;
      hinz_r  <= hinz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign mode_in  = mode_t'(data_byte[1:0]);
  assign k        = seen_r - 7'd1;
  assign left_dec = left_r - 7'd1;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    seen_nxt  = seen_r;
    acc_nxt   = acc_r;
    hinz_nxt  = hinz_r;
    res_valid = 1'b0;
    res       = '0;
    noncanon  = 1'b0;

    case (state_r)
      ST_HEADER: begin
        if (step) begin
          mode_nxt = mode_in;
          seen_nxt = 7'd1;
          hinz_nxt = 1'b0;
          acc_nxt  = {{(ValueW-6){1'b0}}, data_byte[7:2]};
          left_nxt = 7'd1;
          case (mode_in)
            MODE_TWO:  left_nxt = 7'd1;
            MODE_FOUR: left_nxt = 7'd3;
            MODE_BIG: begin
              acc_nxt  = '0;
              left_nxt = {1'b0, data_byte[7:2]} + BIG_EXTRA;
            end
            default: left_nxt = 7'd1;
          endcase
          if (mode_in == MODE_SINGLE) begin
            res_valid          = 1'b1;
            res.value          = acc_nxt;
            res.total_length   = 7'd1;
            res.status         = STATUS_OK;
          end else if (last) begin
            res_valid          = 1'b1;
            res.total_length   = 7'd1;
            res.is_big         = (mode_in == MODE_BIG);
            res.status         = STATUS_EARLY_END;
          end else begin
            state_nxt = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (step) begin
          // lanes do not overlap the header bits, so OR acts as the add
          if (mode_r == MODE_BIG) begin
            if (k < 7'd8) begin
              for (int j = 0; j < 8; j++) begin
                if (k == 7'(j)) acc_nxt[8*j +: 8] = acc_r[8*j +: 8] | data_byte;
              end
            end else if (data_byte != 8'd0) begin
              hinz_nxt = 1'b1;
            end
          end else begin
            for (int j = 0; j < 3; j++) begin
              if (k == 7'(j)) acc_nxt[6+8*j +: 8] = acc_r[6+8*j +: 8] | data_byte;
            end
          end
          seen_nxt = seen_r + 7'd1;
          left_nxt = left_dec;
          noncanon = ((mode_r == MODE_TWO) && (acc_nxt[ValueW-1:6] == '0)) ||
                     ((mode_r == MODE_FOUR) && (acc_nxt[ValueW-1:14] == '0));
          if (left_dec == 7'd0) begin
            res_valid         = 1'b1;
            res.value         = acc_nxt;
            res.total_length  = seen_nxt;
            res.is_big        = (mode_r == MODE_BIG);
            res.big_overflow  = hinz_nxt;
            res.non_canonical = noncanon;
            res.status        = STATUS_OK;
            state_nxt         = ST_HEADER;
          end else if (last) begin
            res_valid         = 1'b1;
            res.total_length  = seen_nxt;
            res.is_big        = (mode_r == MODE_BIG);
            res.status        = STATUS_EARLY_END;
            state_nxt         = ST_HEADER;
          end
        end
      end
      default: state_nxt = ST_HEADER;
    endcase
  end

endmodule

>>> hdl/compact_integer_stream_decoder.sv
// Top level of the compact integer stream decoder: input stage, decoder, result register.
`timescale 1ns / 1ps
`include "compact_integer_stream_decoder_defines.svh"

// Decodes back-to-back compact integers from a byte stream, one byte per item.
// Takes one byte every clock while the result register is free to accept; a result
// for the byte that completes an integer passes the input register, then the
// result register. A result waiting on out_tready holds the decoder, whose input
// register can still take one byte if it is empty. in_tlast marks the last byte of a
// buffer; an integer cut off by it gives a result with the early-end status bit
// set and value zero. In big mode only the low 64 payload bits are returned, and
// big_overflow flags any nonzero payload byte beyond the eighth.

module compact_integer_stream_decoder import cisd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] value, [70:64] total_length, [71] zero
  output logic [3:0]  out_tuser   // [0] is_big, [1] big_overflow, [2] non_canonical, [3] status
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  res_t       out_r;

  logic       out_free;
  logic       adv;
  logic       res_valid;
  res_t       res;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  cisd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (s1_byte_r),
    .last      (s1_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.total_length, out_r.value};
  assign out_tuser  = {out_r.status, out_r.non_canonical, out_r.big_overflow, out_r.is_big};

  // a cut-off integer never reports a value, a non-canonical flag or an overflow flag
  `CISD_ASSERT_IMPL(a_early_end_clean, clk, rst_n,
    out_valid_r && (out_r.status == STATUS_EARLY_END),
    (out_r.value == '0) && !out_r.non_canonical && !out_r.big_overflow)
  // length stays within one header plus 67 payload bytes
  `CISD_ASSERT_IMPL(a_len_range, clk, rst_n, out_valid_r,
    (out_r.total_length != 7'd0) && (out_r.total_length <= 7'd68))
  // non-canonical only applies to two- and four-byte forms
  `CISD_ASSERT_IMPL(a_noncanon_mode, clk, rst_n, out_valid_r && out_r.non_canonical,
    !out_r.is_big && (out_r.total_length == 7'd2 || out_r.total_length == 7'd4))
  // a byte held in the input register is not dropped while the result stalls
  `CISD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !adv, s1_valid_r)

endmodule
